@@ rtl/i2cras_pkg.sv @@
// package for the i2c register access sequencer: codes, state and result types
package i2cras_pkg;

    // command codes on the request channel
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EVENT = 2'd2
    } t_cmd;

    // operations handed to the byte engine
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1,
        OP_SEND    = 3'd2,
        OP_RD_ACK  = 3'd3,
        OP_RD_NACK = 3'd4,
        OP_STOP    = 3'd5
    } t_bus_op;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_SLAW   = 4'd2,
        PH_REG    = 4'd3,
        PH_WDATA  = 4'd4,
        PH_RSTART = 4'd5,
        PH_SLAR   = 4'd6,
        PH_RDATA  = 4'd7
    } t_phase;

    // engine status codes, upper five bits only
    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    typedef struct packed {
        t_phase      phase;
        logic        is_read;
        logic [6:0]  target_addr;
        logic [7:0]  register_addr;
        logic [7:0]  bytes_left;
    } t_seq_state;

    typedef struct packed {
        t_bus_op     bus_op;
        logic [7:0]  bus_tx_byte;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        done_res;
        logic        failed;
        logic        last;
    } t_result;

    localparam t_seq_state SEQ_STATE_RESET = '{
        phase:         PH_IDLE,
        is_read:       1'b0,
        target_addr:   7'd0,
        register_addr: 8'd0,
        bytes_left:    8'd0
    };

endpackage

@@ rtl/i2cras_step.sv @@
// next-state and result logic for one sequencer transaction
module i2cras_step import i2cras_pkg::*; (
    input  t_seq_state  i_state,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_slave_addr,
    input  logic [7:0]  i_reg_addr,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_write_byte,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_bus_rx_byte,
    output t_seq_state  o_state,
    output t_result     o_result
);

    logic [7:0] st;
    logic [7:0] wdata_left;
    logic [7:0] rdata_left;
    logic       more_read;

    assign st         = i_bus_status & STATUS_MASK;
    assign wdata_left = (i_state.bytes_left != 8'd0) ? i_state.bytes_left - 8'd1 : 8'd0;
    assign rdata_left = i_state.bytes_left - 8'd1;
    assign more_read  = (i_state.bytes_left > 8'd1);

    // next state
    always_comb begin
        o_state = i_state;
        case (i_cmd)
            CMD_WRITE, CMD_READ: begin
                if (i_state.phase == PH_IDLE) begin
                    o_state.phase         = PH_START;
                    o_state.is_read       = (i_cmd == CMD_READ);
                    o_state.target_addr   = i_slave_addr;
                    o_state.register_addr = i_reg_addr;
                    o_state.bytes_left    = (i_byte_count == 8'd0) ? 8'd1 : i_byte_count;
                end
            end
            CMD_EVENT: begin
                unique case (i_state.phase)
                    PH_IDLE: ;
                    PH_START: begin
                        o_state.phase = (st == ST_START || st == ST_REP_START) ?
                                        PH_SLAW : PH_IDLE;
                    end
                    PH_SLAW: begin
                        o_state.phase = (st == ST_MT_SLA_ACK) ? PH_REG : PH_IDLE;
                    end
                    PH_REG: begin
                        if (st != ST_MT_DATA_ACK) begin
                            o_state.phase = PH_IDLE;
                        end else if (i_state.is_read) begin
                            o_state.phase = PH_RSTART;
                        end else begin
                            o_state.phase = PH_WDATA;
                        end
                    end
                    PH_WDATA: begin
                        if (st != ST_MT_DATA_ACK) begin
                            o_state.phase = PH_IDLE;
                        end else begin
                            o_state.bytes_left = wdata_left;
                            if (wdata_left == 8'd0) begin
                                o_state.phase = PH_IDLE;
                            end
                        end
                    end
                    PH_RSTART: begin
                        o_state.phase = (st == ST_REP_START) ? PH_SLAR : PH_IDLE;
                    end
                    PH_SLAR: begin
                        o_state.phase = (st == ST_MR_SLA_ACK) ? PH_RDATA : PH_IDLE;
                    end
                    PH_RDATA: begin
                        if (more_read) begin
                            if (st == ST_MR_DATA_ACK) begin
                                o_state.bytes_left = rdata_left;
                            end else begin
                                o_state.phase = PH_IDLE;
                            end
                        end else begin
                            if (st == ST_MR_DATA_NACK) begin
                                o_state.bytes_left = 8'd0;
                            end
                            o_state.phase = PH_IDLE;
                        end
                    end
                    default: o_state.phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    // result of the transaction
    always_comb begin
        o_result = '0;
        case (i_cmd)
            CMD_WRITE, CMD_READ: begin
                if (i_state.phase == PH_IDLE) begin
                    o_result.bus_op = OP_START;
                end
            end
            CMD_EVENT: begin
                unique case (i_state.phase)
                    PH_IDLE: ;
                    PH_START: begin
                        if (st == ST_START || st == ST_REP_START) begin
                            o_result.bus_op      = OP_SEND;
                            o_result.bus_tx_byte = {i_state.target_addr, 1'b0};
                        end else begin
                            o_result.done_res = 1'b1;
                            o_result.failed   = 1'b1;
                        end
                    end
                    PH_SLAW: begin
                        if (st == ST_MT_SLA_ACK) begin
                            o_result.bus_op      = OP_SEND;
                            o_result.bus_tx_byte = i_state.register_addr;
                        end else begin
                            // only a refused write address gets a stop
                            o_result.bus_op   = OP_STOP;
                            o_result.done_res = 1'b1;
                            o_result.failed   = 1'b1;
                        end
                    end
                    PH_REG: begin
                        if (st != ST_MT_DATA_ACK) begin
                            o_result.done_res = 1'b1;
                            o_result.failed   = 1'b1;
                        end else if (i_state.is_read) begin
                            o_result.bus_op = OP_START;
                        end else begin
                            o_result.bus_op      = OP_SEND;
                            o_result.bus_tx_byte = i_write_byte;
                        end
                    end
                    PH_WDATA: begin
                        if (st != ST_MT_DATA_ACK) begin
                            o_result.done_res = 1'b1;
                            o_result.failed   = 1'b1;
                        end else if (wdata_left == 8'd0) begin
                            o_result.bus_op   = OP_STOP;
                            o_result.done_res = 1'b1;
                        end else begin
                            o_result.bus_op      = OP_SEND;
                            o_result.bus_tx_byte = i_write_byte;
                        end
                    end
                    PH_RSTART: begin
                        if (st == ST_REP_START) begin
                            o_result.bus_op      = OP_SEND;
                            o_result.bus_tx_byte = {i_state.target_addr, 1'b1};
                        end else begin
                            o_result.done_res = 1'b1;
                            o_result.failed   = 1'b1;
                        end
                    end
                    PH_SLAR: begin
                        if (st == ST_MR_SLA_ACK) begin
                            o_result.bus_op = more_read ? OP_RD_ACK : OP_RD_NACK;
                        end else begin
                            o_result.done_res = 1'b1;
                            o_result.failed   = 1'b1;
                        end
                    end
                    PH_RDATA: begin
                        if (more_read) begin
                            if (st == ST_MR_DATA_ACK) begin
                                o_result.read_valid = 1'b1;
                                o_result.read_data  = i_bus_rx_byte;
                                o_result.bus_op     = (rdata_left > 8'd1) ?
                                                      OP_RD_ACK : OP_RD_NACK;
                            end else begin
                                o_result.done_res = 1'b1;
                                o_result.failed   = 1'b1;
                            end
                        end else if (st == ST_MR_DATA_NACK) begin
                            o_result.read_valid = 1'b1;
                            o_result.read_data  = i_bus_rx_byte;
                            o_result.last       = 1'b1;
                            o_result.bus_op     = OP_STOP;
                            o_result.done_res   = 1'b1;
                        end else begin
                            o_result.done_res = 1'b1;
                            o_result.failed   = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/i2c_register_access_sequencer_core.sv @@
// top level of the i2c register access sequencer
//
// sits above a byte-level i2c master engine. the request channel (i_valid /
// o_ready) carries begin-write, begin-read and engine completion commands;
// every accepted transaction gives exactly one result on the result channel
// (o_valid / i_ready): the next engine operation, a received data byte with
// its last flag, and done / failed when a transfer ends.
// o_valid rises in the cycle after acceptance; one transaction per cycle is
// sustained while results are taken, set by the single decode step between
// the sequencer state register and the result register.
// a result left waiting does not block the request side as long as it is
// taken in the same cycle: o_ready is high when the result register is empty
// or is being drained. while i_ready stays low a waiting result holds and
// o_ready stays low until that result is taken.
// synchronous active-low reset returns the sequencer to idle with cleared
// address and count fields and empties the result register.
module i2c_register_access_sequencer_core import i2cras_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_slave_addr,
    input  logic [7:0]  i_reg_addr,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_write_byte,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_bus_rx_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_bus_op,
    output logic [7:0]  o_bus_tx_byte,
    output logic        o_read_valid,
    output logic [7:0]  o_read_data,
    output logic        o_done_res,
    output logic        o_failed,
    output logic        o_last
);

    t_seq_state r_state;
    t_seq_state n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic       accept;

    // accept whenever the result slot is free or draining this cycle
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    i2cras_step u_step (
        .i_state       (r_state),
        .i_cmd         (i_cmd),
        .i_slave_addr  (i_slave_addr),
        .i_reg_addr    (i_reg_addr),
        .i_byte_count  (i_byte_count),
        .i_write_byte  (i_write_byte),
        .i_bus_status  (i_bus_status),
        .i_bus_rx_byte (i_bus_rx_byte),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // sequencer state and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_bus_op      = r_result.bus_op;
    assign o_bus_tx_byte = r_result.bus_tx_byte;
    assign o_read_valid  = r_result.read_valid;
    assign o_read_data   = r_result.read_data;
    assign o_done_res    = r_result.done_res;
    assign o_failed      = r_result.failed;
    assign o_last        = r_result.last;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the i2c register access sequencer core
module tb import i2cras_pkg::*; ;

    // command value that the block must ignore
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    // transactions that advance a transfer, spread over three idling phases
    localparam int         ACTIVE_ITEMS = 825;
    localparam int         HOLD_CYCLES  = 300;
    localparam t_result    NO_RESULT    = '0;

    // one request transaction; typed rows carry their expected result
    typedef struct {
        logic [1:0] cmd;
        logic [6:0] slave_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic [7:0] bus_status;
        logic [7:0] bus_rx_byte;
        bit         typed;
        t_result    want;
    } t_stim;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [1:0] i_cmd         = '0;
    logic [6:0] i_slave_addr  = '0;
    logic [7:0] i_reg_addr    = '0;
    logic [7:0] i_byte_count  = '0;
    logic [7:0] i_write_byte  = '0;
    logic [7:0] i_bus_status  = '0;
    logic [7:0] i_bus_rx_byte = '0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_bus_op;
    logic [7:0] o_bus_tx_byte;
    logic       o_read_valid;
    logic [7:0] o_read_data;
    logic       o_done_res;
    logic       o_failed;
    logic       o_last;

    // sequencer state as the predictor sees it
    t_phase     seq_phase    = PH_IDLE;
    logic       seq_is_read  = 1'b0;
    logic [6:0] seq_target   = '0;
    logic [7:0] seq_register = '0;
    logic [7:0] seq_left     = '0;

    t_stim      directed_rows[$];
    t_result    pending_results[$];

    int         snd_idle   = 0;
    int         rcv_idle   = 0;
    bit         hold_start = 1'b0;
    int         errors     = 0;
    int         n_begins   = 0;
    int         n_ignored  = 0;
    int         n_ok       = 0;
    int         n_failed   = 0;
    int         n_rx       = 0;

    i2c_register_access_sequencer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_slave_addr  (i_slave_addr),
        .i_reg_addr    (i_reg_addr),
        .i_byte_count  (i_byte_count),
        .i_write_byte  (i_write_byte),
        .i_bus_status  (i_bus_status),
        .i_bus_rx_byte (i_bus_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bus_op      (o_bus_op),
        .o_bus_tx_byte (o_bus_tx_byte),
        .o_read_valid  (o_read_valid),
        .o_read_data   (o_read_data),
        .o_done_res    (o_done_res),
        .o_failed      (o_failed),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // closes the transfer and drops back to idle
    function automatic void end_transfer(inout t_result r, input bit fail);
        r.done_res = 1'b1;
        r.failed   = fail;
        seq_phase  = PH_IDLE;
    endfunction

    // next engine operation for one transaction, updates the predicted state
    function automatic t_result sequence_step(input t_stim s);
        t_result    r;
        logic [7:0] st;
        r  = '0;
        st = s.bus_status & STATUS_MASK;
        if (s.cmd == CMD_WRITE || s.cmd == CMD_READ) begin
            // a begin while busy leaves everything as it is
            if (seq_phase == PH_IDLE) begin
                seq_is_read  = (s.cmd == CMD_READ);
                seq_target   = s.slave_addr;
                seq_register = s.reg_addr;
                seq_left     = (s.byte_count == 8'd0) ? 8'd1 : s.byte_count;
                r.bus_op     = OP_START;
                seq_phase    = PH_START;
            end
        end else if (s.cmd == CMD_EVENT) begin
            case (seq_phase)
                PH_IDLE: begin
                end
                PH_START: begin
                    if (st == ST_START || st == ST_REP_START) begin
                        r.bus_op      = OP_SEND;
                        r.bus_tx_byte = {seq_target, 1'b0};
                        seq_phase     = PH_SLAW;
                    end else begin
                        end_transfer(r, 1'b1);
                    end
                end
                PH_SLAW: begin
                    if (st == ST_MT_SLA_ACK) begin
                        r.bus_op      = OP_SEND;
                        r.bus_tx_byte = seq_register;
                        seq_phase     = PH_REG;
                    end else begin
                        // the only error that still issues a stop
                        r.bus_op = OP_STOP;
                        end_transfer(r, 1'b1);
                    end
                end
                PH_REG: begin
                    if (st != ST_MT_DATA_ACK) begin
                        end_transfer(r, 1'b1);
                    end else if (seq_is_read) begin
                        r.bus_op  = OP_START;
                        seq_phase = PH_RSTART;
                    end else begin
                        r.bus_op      = OP_SEND;
                        r.bus_tx_byte = s.write_byte;
                        seq_phase     = PH_WDATA;
                    end
                end
                PH_WDATA: begin
                    if (st != ST_MT_DATA_ACK) begin
                        end_transfer(r, 1'b1);
                    end else begin
                        if (seq_left != 8'd0) seq_left = seq_left - 8'd1;
                        if (seq_left == 8'd0) begin
                            r.bus_op = OP_STOP;
                            end_transfer(r, 1'b0);
                        end else begin
                            r.bus_op      = OP_SEND;
                            r.bus_tx_byte = s.write_byte;
                        end
                    end
                end
                PH_RSTART: begin
                    if (st == ST_REP_START) begin
                        r.bus_op      = OP_SEND;
                        r.bus_tx_byte = {seq_target, 1'b1};
                        seq_phase     = PH_SLAR;
                    end else begin
                        end_transfer(r, 1'b1);
                    end
                end
                PH_SLAR: begin
                    if (st == ST_MR_SLA_ACK) begin
                        r.bus_op  = (seq_left > 8'd1) ? OP_RD_ACK : OP_RD_NACK;
                        seq_phase = PH_RDATA;
                    end else begin
                        end_transfer(r, 1'b1);
                    end
                end
                PH_RDATA: begin
                    if (seq_left > 8'd1 && st == ST_MR_DATA_ACK) begin
                        r.read_valid = 1'b1;
                        r.read_data  = s.bus_rx_byte;
                        seq_left     = seq_left - 8'd1;
                        r.bus_op     = (seq_left > 8'd1) ? OP_RD_ACK : OP_RD_NACK;
                    end else if (seq_left <= 8'd1 && st == ST_MR_DATA_NACK) begin
                        r.read_valid = 1'b1;
                        r.read_data  = s.bus_rx_byte;
                        r.last       = 1'b1;
                        r.bus_op     = OP_STOP;
                        seq_left     = 8'd0;
                        end_transfer(r, 1'b0);
                    end else begin
                        end_transfer(r, 1'b1);
                    end
                end
                default: seq_phase = PH_IDLE;
            endcase
        end
        return r;
    endfunction

    // mostly well-formed traffic for the current phase, with some noise
    function automatic t_stim random_stim();
        t_stim      s;
        logic [7:0] good;
        int         pick;
        s.slave_addr  = 7'($urandom);
        s.reg_addr    = 8'($urandom);
        s.byte_count  = 8'($urandom);
        s.write_byte  = 8'($urandom);
        s.bus_status  = 8'($urandom);
        s.bus_rx_byte = 8'($urandom);
        s.typed       = 1'b0;
        s.want        = NO_RESULT;
        if ($urandom_range(99) < 6) begin
            // noise: unused code, begin while busy, event while idle
            s.cmd = 2'($urandom);
        end else if (seq_phase == PH_IDLE) begin
            s.cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
            pick  = $urandom_range(99);
            // mostly short transfers, a few of any length
            if (pick < 65)
                s.byte_count = 8'($urandom_range(3));
            else if (pick < 97)
                s.byte_count = 8'($urandom_range(15, 4));
        end else begin
            s.cmd = CMD_EVENT;
            case (seq_phase)
                PH_START:         good = $urandom_range(1) ? ST_START : ST_REP_START;
                PH_SLAW:          good = ST_MT_SLA_ACK;
                PH_REG, PH_WDATA: good = ST_MT_DATA_ACK;
                PH_RSTART:        good = ST_REP_START;
                PH_SLAR:          good = ST_MR_SLA_ACK;
                default:          good = (seq_left > 8'd1) ? ST_MR_DATA_ACK : ST_MR_DATA_NACK;
            endcase
            // a wrong status now and then breaks the transfer off
            if ($urandom_range(99) >= 4)
                s.bus_status = good | 8'($urandom_range(7));
        end
        return s;
    endfunction

    task automatic row(input logic [1:0] cmd, input logic [6:0] sla, input logic [7:0] rga,
                       input logic [7:0] cnt, input logic [7:0] wb, input logic [7:0] st,
                       input logic [7:0] rx, input bit typed, input t_result want);
        t_stim s;
        s = '{cmd, sla, rga, cnt, wb, st, rx, typed, want};
        directed_rows.push_back(s);
    endtask

    // offer one transaction, hold it until taken, then record what must come back
    task automatic deliver(input t_stim s);
        t_result r;
        if ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        i_valid       <= 1'b1;
        i_cmd         <= s.cmd;
        i_slave_addr  <= s.slave_addr;
        i_reg_addr    <= s.reg_addr;
        i_byte_count  <= s.byte_count;
        i_write_byte  <= s.write_byte;
        i_bus_status  <= s.bus_status;
        i_bus_rx_byte <= s.bus_rx_byte;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (s.cmd == CMD_UNUSED || ((s.cmd == CMD_EVENT) == (seq_phase == PH_IDLE)))
            n_ignored++;
        else if (s.cmd != CMD_EVENT)
            n_begins++;
        r = sequence_step(s);
        if (s.typed) r = s.want;
        if (r.done_res) begin
            if (r.failed) n_failed++;
            else n_ok++;
        end
        if (r.read_valid) n_rx++;
        pending_results.push_back(r);
    endtask

    task automatic check_fld(input string nm, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, want, got);
            errors++;
        end
    endtask

    // result side: random back-pressure, one long hold-off, field checks
    initial begin
        int      hold_cnt;
        t_result want;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual op %0h",
                             $time, o_bus_op);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_fld("bus_op", 8'(want.bus_op), 8'(o_bus_op));
                    check_fld("bus_tx_byte", want.bus_tx_byte, o_bus_tx_byte);
                    check_fld("read_valid", 8'(want.read_valid), 8'(o_read_valid));
                    check_fld("read_data", want.read_data, o_read_data);
                    check_fld("done_res", 8'(want.done_res), 8'(o_done_res));
                    check_fld("failed", 8'(want.failed), 8'(o_failed));
                    check_fld("last", 8'(want.last), 8'(o_last));
                end
            end
            if (hold_start && hold_cnt < HOLD_CYCLES) begin
                // long stall so the core fills up and drops o_ready
                hold_cnt++;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // request side: reset, directed table, then three random phases
    initial begin
        int acted;
        t_stim s;
        acted = 0;

        // event while idle and the unused command give nothing
        row(CMD_EVENT, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, NO_RESULT);
        row(CMD_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, NO_RESULT);
        // single-byte write at the top address, count of zero taken as one
        row(CMD_WRITE, 7'h7F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
            '{OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        // begin while busy is dropped
        row(CMD_READ, 7'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 1'b1, NO_RESULT);
        // low status bits set on the start and address codes, they must be masked off
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_START | 8'h07, 8'h00, 1'b1,
            '{OP_SEND, 8'hFE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK | 8'h07, 8'h00, 1'b1,
            '{OP_SEND, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'hA5, ST_MT_DATA_ACK, 8'h00, 1'b0, NO_RESULT);
        // last data byte acked: stop and done in one go
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MT_DATA_ACK, 8'h00, 1'b1,
            '{OP_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0});
        // two-byte read at address zero, start answered with a repeated-start code
        row(CMD_READ, 7'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_REP_START, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MT_DATA_ACK, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_REP_START, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MR_SLA_ACK, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MR_DATA_ACK, 8'hFF, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MR_DATA_NACK, 8'h00, 1'b0, NO_RESULT);
        // address not acked: the error path that sends a stop
        row(CMD_WRITE, 7'h05, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_START, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 1'b1,
            '{OP_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0});
        // largest count, start refused: failed without a stop
        row(CMD_READ, 7'h55, 8'hAA, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
            '{OP_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0});
        // read whose repeated start comes back with the plain start code
        row(CMD_READ, 7'h2A, 8'h55, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_START, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_MT_DATA_ACK, 8'h00, 1'b0, NO_RESULT);
        row(CMD_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, ST_START, 8'h00, 1'b1,
            '{OP_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 23;
        rcv_idle = 79;
        foreach (directed_rows[k]) deliver(directed_rows[k]);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle = 23;
                    rcv_idle = 79;
                end
                1: begin
                    snd_idle   = 79;
                    rcv_idle   = 23;
                    hold_start = 1'b1;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            while (acted < (ph + 1) * ACTIVE_ITEMS / 3) begin
                s = random_stim();
                if (!(s.cmd == CMD_UNUSED || ((s.cmd == CMD_EVENT) == (seq_phase == PH_IDLE))))
                    acted++;
                deliver(s);
            end
        end
        i_valid <= 1'b0;

        // drain, then idle on so that any extra result from the core would show
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d transfers begun, %0d ended clean, %0d ended in error",
                 n_begins, n_ok, n_failed);
        $display("received %0d read bytes, %0d commands ignored, %0d mismatches",
                 n_rx, n_ignored, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
